@@ hdl/tlvp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Attribute TLV parser package
// Shared word types, phase codes and byte-count constants.
// ----------------------------------------------------------------------------
package tlvp_pkg;

    localparam int unsigned COUNT_W = 16;

    localparam logic [COUNT_W-1:0] HEADER_AND_ID_BYTES = 16'd6;
    localparam logic [COUNT_W-1:0] LENGTH_BYTES        = 16'd2;
    localparam logic [COUNT_W-1:0] ID_BYTES            = 16'd1;

    typedef enum logic [1:0] {
        PH_ID    = 2'd0,
        PH_LEN   = 2'd1,
        PH_VALUE = 2'd2
    } phase_t;

    typedef struct packed {
        logic       restart;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0]         value_byte;
        logic [7:0]         attribute_id;
        logic [COUNT_W-1:0] byte_position;
        logic               last;
    } out_word_t;

endpackage

@@ hdl/tlvp_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Attribute TLV parser state machine
// Tracks header, id, length and value phases and forms one result per value byte.
// ----------------------------------------------------------------------------
module tlvp_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_accept,
    input  tlvp_pkg::in_word_t  in_word,
    output logic                res_valid,
    output tlvp_pkg::out_word_t res_word
);

    tlvp_pkg::phase_t                 phase_reg, phase_next;
    logic [tlvp_pkg::COUNT_W-1:0]     seen_reg, seen_next;
    logic [tlvp_pkg::COUNT_W-1:0]     wanted_reg, wanted_next;
    logic [7:0]                       id_reg, id_next;
    logic [7:0]                       len_low_reg, len_low_next;
    logic [tlvp_pkg::COUNT_W-1:0]     seen_inc;
    logic [tlvp_pkg::COUNT_W-1:0]     len_full;
    logic                             fin;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= tlvp_pkg::PH_ID;
            seen_reg    <= '0;
            wanted_reg  <= tlvp_pkg::HEADER_AND_ID_BYTES;
            id_reg      <= '0;
            len_low_reg <= '0;
        end else begin
            phase_reg   <= phase_next;
            seen_reg    <= seen_next;
            wanted_reg  <= wanted_next;
            id_reg      <= id_next;
            len_low_reg <= len_low_next;
        end
    end

    assign seen_inc = seen_reg + 16'd1;
    assign len_full = {in_word.data_byte, len_low_reg};
    assign fin      = (seen_inc >= wanted_reg);

    always_comb begin
        phase_next   = phase_reg;
        seen_next    = seen_reg;
        wanted_next  = wanted_reg;
        id_next      = id_reg;
        len_low_next = len_low_reg;
        res_valid    = 1'b0;

        res_word.value_byte    = in_word.data_byte;
        res_word.attribute_id  = id_reg;
        res_word.byte_position = seen_reg;
        res_word.last          = fin;

        if (in_accept) begin
            if (in_word.restart) begin
                phase_next  = tlvp_pkg::PH_ID;
                seen_next   = '0;
                wanted_next = tlvp_pkg::HEADER_AND_ID_BYTES;
            end else begin
                case (phase_reg)
                    tlvp_pkg::PH_LEN: begin
                        seen_next = seen_inc;
                        if (seen_inc < wanted_reg) begin
                            len_low_next = in_word.data_byte;
                        end else begin
                            seen_next = '0;
                            if (len_full == '0) begin
                                wanted_next = tlvp_pkg::ID_BYTES;
                                phase_next  = tlvp_pkg::PH_ID;
                            end else begin
                                wanted_next = len_full;
                                phase_next  = tlvp_pkg::PH_VALUE;
                            end
                        end
                    end
                    tlvp_pkg::PH_VALUE: begin
                        res_valid = 1'b1;
                        seen_next = seen_inc;
                        if (fin) begin
                            seen_next   = '0;
                            wanted_next = tlvp_pkg::ID_BYTES;
                            phase_next  = tlvp_pkg::PH_ID;
                        end
                    end
                    default: begin
                        seen_next = seen_inc;
                        if (!(seen_inc < wanted_reg)) begin
                            id_next     = in_word.data_byte;
                            seen_next   = '0;
                            wanted_next = tlvp_pkg::LENGTH_BYTES;
                            phase_next  = tlvp_pkg::PH_LEN;
                        end
                    end
                endcase
            end
        end
    end

endmodule

@@ hdl/tlvp_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Attribute TLV parser result register
// Holds one result word and lets a new input word in whenever it is free or drains.
// ----------------------------------------------------------------------------
module tlvp_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                res_valid,
    input  tlvp_pkg::out_word_t res_word,
    output logic                in_ready,
    input  logic                m_ready,
    output logic                m_valid,
    output tlvp_pkg::out_word_t m_data
);

    logic                valid_reg, valid_next;
    tlvp_pkg::out_word_t data_reg;

    assign in_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && res_valid) begin
            data_reg <= res_word;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

@@ hdl/notification_attribute_tlv_parser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Notification attribute TLV parser
// Streams the value bytes of each attribute in an attribute-response stream.
// ----------------------------------------------------------------------------
// The input channel (s_valid, s_ready, s_data) carries one word per stream
// byte, or a restart word that sends the parser back to skipping the header.
// The result channel (m_valid, m_ready, m_data) carries one word per value
// byte, tagged with its attribute id, its offset in the value and a last flag.
// Header, id and length bytes, restarts and zero-length attributes give no
// result word.
// A result word appears in the cycle after its input word is accepted. The
// block takes one input word per cycle while the receiver keeps up; the single
// result register sets that figure. When the receiver stalls with a result held,
// s_ready drops until the result is taken, so nothing is lost. Reset empties the
// result register and puts the parser into header-skip mode, as a restart does.
// ----------------------------------------------------------------------------
module notification_attribute_tlv_parser_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tlvp_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tlvp_pkg::out_word_t m_data
);

    logic                res_valid;
    tlvp_pkg::out_word_t res_word;
    logic                in_accept;

    assign in_accept = s_valid && s_ready;

    tlvp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_word   (s_data),
        .res_valid (res_valid),
        .res_word  (res_word)
    );

    tlvp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_word  (res_word),
        .in_ready  (s_ready),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule

@@ verif/tlvp_stream_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Attribute TLV parser stream checker
// Watches both channels of the parser. Every input word taken by the block is
// run through a local parser model, and every value word it yields is queued.
// Each result word taken from the block is checked field by field against the
// oldest queued word.
// ----------------------------------------------------------------------------
module tlvp_stream_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  tlvp_pkg::in_word_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  tlvp_pkg::out_word_t m_data,
    output int                  fail_count,
    output int                  outstanding
);

    tlvp_pkg::phase_t                 parse_phase;
    logic [tlvp_pkg::COUNT_W-1:0]     seen_count;
    logic [tlvp_pkg::COUNT_W-1:0]     want_count;
    logic [7:0]                       attr_id;
    logic [7:0]                       len_low_byte;
    tlvp_pkg::out_word_t              expected_words[$];

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    function void restart_parse();
        parse_phase = tlvp_pkg::PH_ID;
        seen_count  = '0;
        want_count  = tlvp_pkg::HEADER_AND_ID_BYTES;
    endfunction

    task report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function void predict_value_byte(input tlvp_pkg::in_word_t w);
        logic [tlvp_pkg::COUNT_W-1:0] attr_len;
        tlvp_pkg::out_word_t          r;
        if (w.restart) begin
            restart_parse();
        end else begin
            case (parse_phase)
                tlvp_pkg::PH_LEN: begin
                    seen_count = seen_count + 16'd1;
                    if (seen_count < want_count) begin
                        len_low_byte = w.data_byte;
                    end else begin
                        attr_len   = {w.data_byte, len_low_byte};
                        seen_count = '0;
                        if (attr_len == '0) begin
                            want_count  = tlvp_pkg::ID_BYTES;
                            parse_phase = tlvp_pkg::PH_ID;
                        end else begin
                            want_count  = attr_len;
                            parse_phase = tlvp_pkg::PH_VALUE;
                        end
                    end
                end
                tlvp_pkg::PH_VALUE: begin
                    r.value_byte    = w.data_byte;
                    r.attribute_id  = attr_id;
                    r.byte_position = seen_count;
                    seen_count      = seen_count + 16'd1;
                    r.last          = (seen_count >= want_count);
                    expected_words.push_back(r);
                    if (r.last) begin
                        seen_count  = '0;
                        want_count  = tlvp_pkg::ID_BYTES;
                        parse_phase = tlvp_pkg::PH_ID;
                    end
                end
                default: begin
                    seen_count = seen_count + 16'd1;
                    if (seen_count >= want_count) begin
                        attr_id     = w.data_byte;
                        seen_count  = '0;
                        want_count  = tlvp_pkg::LENGTH_BYTES;
                        parse_phase = tlvp_pkg::PH_LEN;
                    end
                end
            endcase
        end
    endfunction

    always @(posedge aclk) begin
        tlvp_pkg::out_word_t want;
        if (!aresetn) begin
            restart_parse();
            attr_id      = '0;
            len_low_byte = '0;
            expected_words.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("result word %h with none expected", m_data));
                end else begin
                    want = expected_words.pop_front();
                    if (m_data.value_byte !== want.value_byte) begin
                        report_mismatch($sformatf("value_byte got %h, want %h",
                                                  m_data.value_byte, want.value_byte));
                    end
                    if (m_data.attribute_id !== want.attribute_id) begin
                        report_mismatch($sformatf("attribute_id got %h, want %h",
                                                  m_data.attribute_id, want.attribute_id));
                    end
                    if (m_data.byte_position !== want.byte_position) begin
                        report_mismatch($sformatf("byte_position got %0d, want %0d",
                                                  m_data.byte_position, want.byte_position));
                    end
                    if (m_data.last !== want.last) begin
                        report_mismatch($sformatf("last got %b, want %b",
                                                  m_data.last, want.last));
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_value_byte(s_data);
            end
        end
        outstanding = expected_words.size();
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Attribute TLV parser testbench
// Feeds the parser a short directed stream, a long receiver stall, random
// attribute responses mixed with cut-off and noisy streams, and a 256-byte
// attribute near the end. Both sides idle in random bursts. The stream checker
// predicts and compares; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam longint WATCHDOG_NS  = 12_000_000;
    localparam int     RANDOM_WORDS = 1300;
    localparam int     HOLD_CYCLES  = 400;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    tlvp_pkg::in_word_t  s_data;
    logic                m_valid;
    logic                m_ready;
    tlvp_pkg::out_word_t m_data;

    int fail_count;
    int outstanding;
    int words_sent;
    int send_idle_pct;
    int ready_idle_pct;
    bit hold_request;
    int idle_levels[3] = '{0, 4, 25};

    notification_attribute_tlv_parser_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    tlvp_stream_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(WATCHDOG_NS);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int burst;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end else if ($urandom_range(1, 100) <= ready_idle_pct) begin
                burst = $urandom_range(1, 18);
                m_ready <= 1'b0;
                repeat (burst - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic drive_word(input logic is_restart, input logic [7:0] data);
        int gap;
        if ($urandom_range(1, 100) <= send_idle_pct) begin
            gap = $urandom_range(1, 18);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{restart: is_restart, data_byte: data};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        words_sent++;
    endtask

    task automatic send_header();
        repeat (5) drive_word(1'b0, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_attribute(input logic [7:0] id, input logic [15:0] attr_len);
        drive_word(1'b0, id);
        drive_word(1'b0, attr_len[7:0]);
        drive_word(1'b0, attr_len[15:8]);
        repeat (attr_len) drive_word(1'b0, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        int rand_start;
        int pick;
        int attr_len;
        s_valid        = 1'b0;
        s_data         = '0;
        aresetn        = 1'b0;
        send_idle_pct  = 10;
        ready_idle_pct = 10;
        hold_request   = 1'b0;
        words_sent     = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Header with extreme bytes, then id 0 with a single value word.
        drive_word(1'b0, 8'h00);
        drive_word(1'b0, 8'hFF);
        drive_word(1'b0, 8'hAA);
        drive_word(1'b0, 8'h55);
        drive_word(1'b0, 8'h12);
        drive_word(1'b0, 8'h00);
        drive_word(1'b0, 8'h01);
        drive_word(1'b0, 8'h00);
        drive_word(1'b0, 8'hFF);
        // A zero-length attribute gives no result word.
        drive_word(1'b0, 8'hFF);
        drive_word(1'b0, 8'h00);
        drive_word(1'b0, 8'h00);
        drive_word(1'b0, 8'h7E);
        drive_word(1'b0, 8'h03);
        drive_word(1'b0, 8'h00);
        drive_word(1'b0, 8'h00);
        drive_word(1'b0, 8'h80);
        drive_word(1'b0, 8'hFF);
        // Restart inside a value, then again inside the header.
        drive_word(1'b0, 8'h11);
        drive_word(1'b0, 8'h05);
        drive_word(1'b0, 8'h00);
        drive_word(1'b0, 8'hC3);
        drive_word(1'b0, 8'h3C);
        drive_word(1'b1, 8'hFF);
        drive_word(1'b0, 8'h01);
        drive_word(1'b0, 8'h02);
        drive_word(1'b1, 8'h00);

        // The receiver stalls for a long stretch while value words keep coming.
        send_idle_pct = 0;
        hold_request  = 1'b1;
        send_header();
        send_attribute(8'h42, 16'd40);

        rand_start = words_sent;
        while (words_sent - rand_start < RANDOM_WORDS) begin
            if (words_sent - rand_start > RANDOM_WORDS - 250) begin
                send_idle_pct  = 0;
                ready_idle_pct = 0;
            end else begin
                send_idle_pct  = idle_levels[$urandom_range(0, 2)];
                ready_idle_pct = idle_levels[$urandom_range(0, 2)];
            end
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                if ($urandom_range(0, 3) != 0) begin
                    drive_word(1'b1, 8'($urandom_range(0, 255)));
                end
                send_header();
                repeat ($urandom_range(1, 4)) begin
                    pick = $urandom_range(0, 99);
                    attr_len = (pick < 12) ? 0 :
                               (pick < 80) ? $urandom_range(1, 8) :
                               (pick < 97) ? $urandom_range(9, 40) :
                                             $urandom_range(256, 262);
                    send_attribute(8'($urandom_range(0, 255)), 16'(attr_len));
                end
            end else if (pick < 90) begin
                drive_word(1'b1, 8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 7)) drive_word(1'b0, 8'($urandom_range(0, 255)));
                drive_word(1'b1, 8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 10)) begin
                    drive_word($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
                end
            end
        end

        // A 256-byte attribute has a zero low length byte.
        send_idle_pct  = 0;
        ready_idle_pct = 0;
        drive_word(1'b1, 8'h00);
        send_header();
        send_attribute(8'hA5, 16'h0100);
        send_attribute(8'h5A, 16'd2);

        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/tlvp_pkg.sv
hdl/tlvp_parser.sv
hdl/tlvp_out_reg.sv
hdl/notification_attribute_tlv_parser_top.sv
verif/tlvp_stream_checker.sv
verif/tb_top.sv
